### rtl/core/bet_pkg.sv
// Shared types and constants for the cubic Bezier ease table generator.
// Depends on nothing; used by every module under rtl/core.
package bet_pkg;
  localparam int QW = 32;
  localparam int FRAC = 28;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = -32'sh7fffffff - 32'sd1;
  localparam logic signed [31:0] ONE_Q = 32'sh10000000;
  localparam logic [31:0] TOL_Q = 32'd26844;
  // 2^28 = 127*CTRL_STEP + 1
  localparam logic [31:0] CTRL_STEP = 32'd2113665;

  // Saturate a wide signed value to Q4.28.
  function automatic logic signed [31:0] sat_q(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(Q_MAX)) r = Q_MAX;
    else if (v < 66'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Control byte to Q4.28: floor((c*2^28+63)/127). The leftover c+63 over
  // 127 adds one from c = 64 up.
  function automatic logic signed [31:0] ctrl_q(input logic [6:0] c);
    return 32'(c) * CTRL_STEP + {31'd0, c[6]};
  endfunction

  // Divider request/response bundle.
  typedef struct packed {
    logic start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] quo;
  } div_rsp_t;
endpackage

### rtl/core/bezier_ease_table_gen.sv
// Cubic Bezier ease table generator. One curve (four 7-bit control bytes)
// enters; a straight line yields one result marked linear, otherwise
// TABLE_SIZE results follow, one per sample, in index order. Each sample
// runs up to MAX_ITER Newton steps on one shared 32x32 multiply-add unit
// (a curve pass of 3 products, a slope pass of 2) and a serial divider; a
// sample ends its Newton steps early once it converges or its slope is zero,
// and it waits while the previous result is still held on the result side.
// The input is not ready while a curve is being worked or a result waits.
module bezier_ease_table_gen
  import bet_pkg::*;
#(
  parameter int TABLE_SIZE = 64,
  parameter int MAX_ITER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_ctrl_x1,
  input  logic [6:0]  in_ctrl_y1,
  input  logic [6:0]  in_ctrl_x2,
  input  logic [6:0]  in_ctrl_y2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_linear,
  output logic [5:0]  out_entry_index,
  output logic [15:0] out_curve_value,
  output logic        out_last
);
  localparam int IW = $clog2(MAX_ITER + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_SETUP = 4'd1, S_EV = 4'd2,
    S_CHK = 4'd3, S_SL = 4'd4, S_DIV = 4'd5, S_YEV = 4'd6, S_OUT = 4'd7,
    S_YSET = 4'd8;
  // Sample point x = (2d+1)*2^28/XDEN kept as quotient and remainder
  localparam int XDEN = 2 * TABLE_SIZE;
  localparam logic signed [31:0] XS_FIRST = 32'((longint'(1) << FRAC) / XDEN);
  localparam logic [7:0] XR_FIRST = 8'((longint'(1) << FRAC) % XDEN);
  localparam logic signed [31:0] XS_STEP = 32'((longint'(1) << (FRAC + 1)) / XDEN);
  localparam logic [7:0] XR_STEP = 8'((longint'(1) << (FRAC + 1)) % XDEN);
  localparam logic [7:0] XR_WRAP = 8'(XDEN);

  logic [3:0] st_r, st_nxt;
  logic signed [31:0] p1_r, p2_r, q1_r, q2_r, t_r, xs_r, acc_r, v_r;
  logic signed [31:0] p1_nxt, p2_nxt, q1_nxt, q2_nxt, t_nxt, xs_nxt, acc_nxt,
    v_nxt;
  logic signed [31:0] ka_r, kb_r, kc_r, ka_nxt, kb_nxt, kc_nxt;
  logic [7:0] xr_r, xr_nxt, xr_sum;
  logic [1:0] ph_r, ph_nxt;
  logic [5:0] d_r, d_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic ov_r, ov_nxt, olin_r, olin_nxt, olast_r, olast_nxt;
  logic [5:0] oidx_r, oidx_nxt;
  logic [15:0] oval_r, oval_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic mulv_r, mulv_nxt;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [31:0] mprod, bv, cv, abs_v;
  logic signed [65:0] ysh;

  bet_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Floor of the registered product by 2^28, saturated
  assign mprod = sat_q(66'(prod_r >>> FRAC));
  assign abs_v = v_r[31] ? -v_r : v_r;
  assign ysh = 66'(acc_r >>> 12);
  assign xr_sum = xr_r + XR_STEP;

  always_comb begin
    st_nxt = st_r; p1_nxt = p1_r; p2_nxt = p2_r; q1_nxt = q1_r; q2_nxt = q2_r;
    t_nxt = t_r; xs_nxt = xs_r; acc_nxt = acc_r; v_nxt = v_r; ph_nxt = ph_r;
    ka_nxt = ka_r; kb_nxt = kb_r; kc_nxt = kc_r; xr_nxt = xr_r;
    d_nxt = d_r; k_nxt = k_r; ov_nxt = ov_r; olin_nxt = olin_r;
    olast_nxt = olast_r; oidx_nxt = oidx_r; oval_nxt = oval_r;
    mulv_nxt = 1'b0; prod_nxt = prod_r;
    dreq = '{start: 1'b0, num: v_r, den: acc_r};
    bv = kb_r; cv = kc_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          if (in_ctrl_x1 == in_ctrl_y1 && in_ctrl_x2 == in_ctrl_y2) begin
            ov_nxt = 1'b1; olin_nxt = 1'b1; oidx_nxt = '0; oval_nxt = '0;
            olast_nxt = 1'b1;
          end else begin
            p1_nxt = ctrl_q(in_ctrl_x1); p2_nxt = ctrl_q(in_ctrl_x2);
            q1_nxt = ctrl_q(in_ctrl_y1); q2_nxt = ctrl_q(in_ctrl_y2);
            xs_nxt = XS_FIRST; xr_nxt = XR_FIRST;
            d_nxt = '0; st_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        // Start a sample at t = x
        t_nxt = xs_r;
        k_nxt = '0;
        ka_nxt = sat_q(66'(ONE_Q) + 66'(3) * 66'(p1_r) - 66'(3) * 66'(p2_r));
        kb_nxt = sat_q(66'(3) * 66'(p2_r) - 66'(6) * 66'(p1_r));
        kc_nxt = sat_q(66'(3) * 66'(p1_r));
        acc_nxt = ka_nxt; ph_nxt = '0; st_nxt = S_EV;
      end
      S_EV, S_SL, S_YEV: begin
        // Horner pass on the shared multiplier: multiply, then add
        if (!mulv_r) begin
          prod_nxt = 64'(acc_r) * 64'(t_r); mulv_nxt = 1'b1;
        end else begin
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd0) acc_nxt = sat_q(66'(mprod) + 66'(bv));
          else if (ph_r == 2'd1) acc_nxt = sat_q(66'(mprod) + 66'(cv));
          else acc_nxt = mprod;
          if ((st_r != S_EV && st_r != S_YEV && ph_r == 2'd1) || ph_r == 2'd2) begin
            if (st_r == S_EV) begin
              v_nxt = sat_q(66'(mprod) - 66'(xs_r)); st_nxt = S_CHK;
            end else if (st_r == S_SL) begin
              st_nxt = S_DIV; dreq.start = 1'b0;
            end else begin
              st_nxt = S_OUT;
            end
          end
        end
      end
      S_CHK: begin
        if (32'(abs_v) < TOL_Q || k_r == IW'(MAX_ITER)) begin
          st_nxt = S_YSET;
        end else begin
          ka_nxt = sat_q(66'(3) * 66'(ka_r)); kb_nxt = sat_q(66'(2) * 66'(kb_r));
          acc_nxt = ka_nxt; ph_nxt = '0; st_nxt = S_SL;
        end
      end
      S_DIV: begin
        // Issue division once (skip to the y pass if the slope is zero), wait for quotient
        if (ph_r != 2'd3) begin
          if (acc_r == 32'sd0) begin
            st_nxt = S_YSET;
          end else begin
            dreq.start = 1'b1; ph_nxt = 2'd3;
          end
        end else if (drsp.done) begin
          t_nxt = sat_q(66'(t_r) - 66'(drsp.quo)); k_nxt = k_r + IW'(1);
          ka_nxt = sat_q(66'(ONE_Q) + 66'(3) * 66'(p1_r) - 66'(3) * 66'(p2_r));
          kb_nxt = sat_q(66'(3) * 66'(p2_r) - 66'(6) * 66'(p1_r));
          acc_nxt = ka_nxt; ph_nxt = '0; st_nxt = S_EV;
        end
      end
      S_YSET: begin
        ka_nxt = sat_q(66'(ONE_Q) + 66'(3) * 66'(q1_r) - 66'(3) * 66'(q2_r));
        kb_nxt = sat_q(66'(3) * 66'(q2_r) - 66'(6) * 66'(q1_r));
        kc_nxt = sat_q(66'(3) * 66'(q1_r));
        acc_nxt = ka_nxt; ph_nxt = '0; st_nxt = S_YEV;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!ov_r) begin
          ov_nxt = 1'b1; olin_nxt = 1'b0; oidx_nxt = d_r;
          olast_nxt = (d_r == 6'(TABLE_SIZE - 1));
          if (acc_r[31]) oval_nxt = '0;
          else if (ysh > 66'sd65535) oval_nxt = 16'hffff;
          else oval_nxt = ysh[15:0];
          if (d_r == 6'(TABLE_SIZE - 1)) st_nxt = S_IDLE;
          else begin
            d_nxt = d_r + 6'd1; st_nxt = S_SETUP;
            // Advance the sample point, carrying the remainder
            if (xr_sum >= XR_WRAP) begin
              xs_nxt = xs_r + XS_STEP + 32'sd1; xr_nxt = xr_sum - XR_WRAP;
            end else begin
              xs_nxt = xs_r + XS_STEP; xr_nxt = xr_sum;
            end
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (mulv_r && st_nxt == st_r && ph_nxt != ph_r) mulv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt; p2_r <= p2_nxt; q1_r <= q1_nxt; q2_r <= q2_nxt;
    t_r <= t_nxt; xs_r <= xs_nxt; acc_r <= acc_nxt; v_r <= v_nxt;
    ka_r <= ka_nxt; kb_r <= kb_nxt; kc_r <= kc_nxt; d_r <= d_nxt; k_r <= k_nxt;
    olin_r <= olin_nxt; olast_r <= olast_nxt; oidx_r <= oidx_nxt;
    oval_r <= oval_nxt; prod_r <= prod_nxt; xr_r <= xr_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; mulv_r <= 1'b0; ph_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; mulv_r <= mulv_nxt; ph_r <= ph_nxt;
    end
  end

  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_is_linear = olin_r;
  assign out_entry_index = oidx_r;
  assign out_curve_value = oval_r;
  assign out_last = olast_r;

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_curve_value)))
    else $error("result dropped");
  a_lin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_linear) |-> out_last) else $error("linear not last");
`endif
endmodule

### rtl/core/bet_div.sv
// Radix-2 restoring divider: trunc(num*2^28/den), saturated to Q4.28.
// Depends on bet_pkg.
module bet_div
  import bet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [59:0] dvd_r, dvd_nxt;
  logic [60:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [59:0] quo_r, quo_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [60:0] trial;
  logic [31:0] an, ad;
  logic signed [65:0] sq;

  always_comb begin
    an = req.num[31] ? 32'(-req.num) : 32'(req.num);
    ad = req.den[31] ? 32'(-req.den) : 32'(req.den);
    trial = {rem_r[59:0], dvd_r[59]} - {29'd0, dvs_r};
    dvd_nxt = dvd_r; rem_nxt = rem_r; dvs_nxt = dvs_r; quo_nxt = quo_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    // Load operands
    if (req.start) begin
      dvd_nxt = {an, 28'd0}; rem_nxt = '0; dvs_nxt = ad; quo_nxt = '0;
      neg_nxt = req.num[31] ^ req.den[31]; cnt_nxt = 6'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one quotient bit per cycle
      if (!trial[60]) begin
        rem_nxt = trial; quo_nxt = {quo_r[58:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[59:0], dvd_r[59]}; quo_nxt = {quo_r[58:0], 1'b0};
      end
      dvd_nxt = {dvd_r[58:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd59) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; quo_r <= quo_nxt;
    neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign sq = neg_r ? -$signed({6'd0, quo_r}) : $signed({6'd0, quo_r});
  assign rsp.done = done_r;
  assign rsp.quo = sat_q(sq);
endmodule

### dv/bezier_ease_table_gen_chk.sv
// Checker for the Bezier ease table generator: watches both channels, predicts
// each curve's table from the control bytes and compares every result transaction.
// Uses no package; instantiated by bezier_ease_table_gen_tb.
`timescale 1ns / 100ps
module bezier_ease_table_gen_chk #(
  parameter int TABLE_SIZE = 64,
  parameter int MAX_ITER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [6:0]  in_ctrl_x1,
  input  logic [6:0]  in_ctrl_y1,
  input  logic [6:0]  in_ctrl_x2,
  input  logic [6:0]  in_ctrl_y2,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_is_linear,
  input  logic [5:0]  out_entry_index,
  input  logic [15:0] out_curve_value,
  input  logic        out_last,
  output int          errors,
  output int          pending
);
  localparam longint ONE = longint'(1) << 28;
  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam longint TOL = 26844;

  typedef struct {
    logic        is_linear;
    logic [5:0]  index;
    logic [15:0] value;
    logic        last;
  } entry_t;

  entry_t table_q[$];

  function automatic longint clamp_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return clamp_q((a * b) >>> 28);
  endfunction

  // Horner form of the cubic with control points p1, p2
  function automatic longint bez_pos(longint t, longint p1, longint p2);
    longint ca, cb, cc, r;
    ca = clamp_q(ONE + 3 * p1 - 3 * p2);
    cb = clamp_q(3 * p2 - 6 * p1);
    cc = clamp_q(3 * p1);
    r = clamp_q(mul_q(ca, t) + cb);
    r = clamp_q(mul_q(r, t) + cc);
    return mul_q(r, t);
  endfunction

  function automatic longint bez_slope(longint t, longint p1, longint p2);
    longint ca3, cb2, cc, r;
    ca3 = clamp_q(3 * clamp_q(ONE + 3 * p1 - 3 * p2));
    cb2 = clamp_q(2 * clamp_q(3 * p2 - 6 * p1));
    cc = clamp_q(3 * p1);
    r = clamp_q(mul_q(ca3, t) + cb2);
    return clamp_q(mul_q(r, t) + cc);
  endfunction

  function automatic longint byte_to_q(logic [6:0] c);
    return (longint'(c) * ONE + 63) / 127;
  endfunction

  // Build the expected table for one curve
  function automatic void predict_table(logic [6:0] cx1, logic [6:0] cy1,
                                        logic [6:0] cx2, logic [6:0] cy2);
    longint x1, y1, x2, y2, xs, t, v, s, y;
    entry_t e;
    if (cx1 == cy1 && cx2 == cy2) begin
      e = '{1'b1, 6'd0, 16'd0, 1'b1};
      table_q.push_back(e);
      return;
    end
    x1 = byte_to_q(cx1);
    y1 = byte_to_q(cy1);
    x2 = byte_to_q(cx2);
    y2 = byte_to_q(cy2);
    for (int d = 0; d < TABLE_SIZE; d++) begin
      xs = (longint'(2 * d + 1) * ONE) / (2 * TABLE_SIZE);
      t = xs;
      for (int k = 0; k < MAX_ITER; k++) begin
        v = clamp_q(bez_pos(t, x1, x2) - xs);
        if ((v < 0 ? -v : v) < TOL) break;
        s = bez_slope(t, x1, x2);
        if (s == 0) break;
        t = clamp_q(t - clamp_q((v * ONE) / s));
      end
      y = bez_pos(t, y1, y2) >>> 12;
      if (y < 0) y = 0;
      if (y > 65535) y = 65535;
      e = '{1'b0, 6'(d), 16'(y), d == TABLE_SIZE - 1};
      table_q.push_back(e);
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = table_q.size();

  initial errors = 0;

  // Predict on each input transaction, compare on each result transaction
  always @(posedge clk) begin
    entry_t e;
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_table(in_ctrl_x1, in_ctrl_y1, in_ctrl_x2, in_ctrl_y2);
      if (out_valid && out_ready) begin
        if (table_q.size() == 0) begin
          report("unexpected result, index", out_entry_index, -1);
        end else begin
          e = table_q.pop_front();
          if (out_is_linear !== e.is_linear) report("is_linear", out_is_linear, e.is_linear);
          if (out_entry_index !== e.index) report("entry_index", out_entry_index, e.index);
          if (out_curve_value !== e.value) report("curve_value", out_curve_value, e.value);
          if (out_last !== e.last) report("last", out_last, e.last);
        end
      end
    end
  end
endmodule

### dv/bezier_ease_table_gen_tb.sv
// Top of the Bezier ease table generator testbench: clock, reset, curve stimulus,
// result back-pressure, watchdog and verdict. Depends on the block (which uses
// bet_pkg) and bezier_ease_table_gen_chk.
`timescale 1ns / 100ps
module bezier_ease_table_gen_tb;
  localparam int RAND_CURVES = 340;
  localparam int CALM_TAIL = 40;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [6:0]  in_ctrl_x1 = '0;
  logic [6:0]  in_ctrl_y1 = '0;
  logic [6:0]  in_ctrl_x2 = '0;
  logic [6:0]  in_ctrl_y2 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_linear;
  logic [5:0]  out_entry_index;
  logic [15:0] out_curve_value;
  logic        out_last;
  int          errors;
  int          pending;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  bezier_ease_table_gen dut (.*);

  bezier_ease_table_gen_chk chk (.*);

  // Stall the result side in random bursts, except in the calm tail
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one curve, at times after a random gap outside the calm tail, and hold it until accepted
  task automatic send_curve(logic [6:0] x1, logic [6:0] y1, logic [6:0] x2, logic [6:0] y2);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ctrl_x1 <= x1;
    in_ctrl_y1 <= y1;
    in_ctrl_x2 <= x2;
    in_ctrl_y2 <= y2;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    logic [6:0] a, b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: straight lines, corner curves, flat and steep slopes
    send_curve(7'd0, 7'd0, 7'd0, 7'd0);
    send_curve(7'd127, 7'd127, 7'd127, 7'd127);
    send_curve(7'd127, 7'd127, 7'd0, 7'd0);
    send_curve(7'd0, 7'd127, 7'd127, 7'd0);
    send_curve(7'd127, 7'd0, 7'd0, 7'd127);
    send_curve(7'd0, 7'd0, 7'd127, 7'd127 - 7'd1);
    send_curve(7'd127, 7'd0, 7'd127, 7'd127);
    send_curve(7'd0, 7'd127, 7'd0, 7'd127);
    send_curve(7'd127, 7'd127, 7'd127, 7'd0);
    send_curve(7'd0, 7'd0, 7'd0, 7'd127);
    send_curve(7'd127, 7'd0, 7'd127, 7'd0);
    send_curve(7'd0, 7'd127, 7'd127, 7'd127);
    send_curve(7'd53, 7'd13, 7'd74, 7'd127);
    send_curve(7'd42, 7'd0, 7'd74, 7'd127);
    send_curve(7'd85, 7'd127, 7'd42, 7'd0);
    send_curve(7'd64, 7'd64, 7'd64, 7'd63);

    // Hold off the sender until the table drains
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random curves; about a quarter are straight lines
    for (int i = 0; i < RAND_CURVES; i++) begin
      if (i == RAND_CURVES - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        a = 7'($urandom);
        b = 7'($urandom);
        send_curve(a, a, b, b);
      end else begin
        send_curve(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### filelist.f
rtl/core/bet_pkg.sv
rtl/core/bet_div.sv
rtl/core/bezier_ease_table_gen.sv
dv/bezier_ease_table_gen_chk.sv
dv/bezier_ease_table_gen_tb.sv
